/* rtl/core/tos_pkg.sv */
// Shared constants, codes and helpers for the typed operand stack.
package tos_pkg;

    localparam int SLOT_DEPTH_DEF     = 256;
    localparam int REAL_TYPE_BITS_DEF = 4;

    localparam int SLOT_W      = 32;
    localparam int VALUE_W     = 64;
    localparam int KIND_W      = 2;
    localparam int TYPE_W      = 3;
    localparam int RT_IN_W     = 4;
    localparam int RTYPE_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int LIMIT_W     = 9;
    localparam int CFG_INDEX_W = 8;

    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 9'd256;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    // Type tags
    localparam logic [TYPE_W-1:0] TAG_INT    = 3'd0;
    localparam logic [TYPE_W-1:0] TAG_FLOAT  = 3'd1;
    localparam logic [TYPE_W-1:0] TAG_LONG   = 3'd2;
    localparam logic [TYPE_W-1:0] TAG_DOUBLE = 3'd3;
    localparam logic [TYPE_W-1:0] TAG_BOOL   = 3'd4;
    localparam logic [TYPE_W-1:0] TAG_REF    = 3'd5;

    localparam logic [RTYPE_W-1:0] TYPE_NONE = 8'd255;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_REFS  = 8'd1;

    // True when an entry of this type occupies two slots
    function automatic logic takes_two(input logic [TYPE_W-1:0] tag, input logic wide_refs);
        takes_two = (tag == TAG_LONG) || (tag == TAG_DOUBLE) || ((tag == TAG_REF) && wide_refs);
    endfunction

endpackage

/* rtl/core/tos_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/typed_operand_stack.sv */
// Typed operand stack of 32-bit slots with type and real-type tags per entry.
//
//   channel   handshake               payload
//   -------   ---------------------   ---------------------------------------------
//   input     in_valid / in_stall     kind, value, type_tag, real_type,
//                                     real_type_given
//   output    out_valid / out_stall   result_value, result_type, result_real_type,
//                                     status, slots_used, is_empty
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word is taken each cycle unless the input stalls; its result is registered
// at the output. The top two slots and the top tag are prefetched each cycle from
// the even and odd slot banks and the tag RAM, so a single pass settles each word.
// Reset clears the counters and the output valid; slot and tag RAMs are not
// cleared. The input stalls only while a held result is stalled at the output.
module typed_operand_stack #(
    parameter int SLOT_DEPTH     = tos_pkg::SLOT_DEPTH_DEF,
    parameter int REAL_TYPE_BITS = tos_pkg::REAL_TYPE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tos_pkg::KIND_W-1:0]           kind,
    input  logic [tos_pkg::VALUE_W-1:0]          value,
    input  logic [tos_pkg::TYPE_W-1:0]           type_tag,
    input  logic [tos_pkg::RT_IN_W-1:0]          real_type,
    input  logic                                 real_type_given,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tos_pkg::VALUE_W-1:0]          result_value,
    output logic [tos_pkg::RTYPE_W-1:0]          result_type,
    output logic [tos_pkg::RT_IN_W-1:0]          result_real_type,
    output logic [tos_pkg::STATUS_W-1:0]         status,
    output logic [tos_pkg::LIMIT_W-1:0]          slots_used,
    output logic                                 is_empty,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tos_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tos_pkg::LIMIT_W-1:0]          cfg_data
);

    localparam int CW         = $clog2(SLOT_DEPTH + 1);
    localparam int AW         = $clog2(SLOT_DEPTH);
    localparam int EVEN_DEPTH = (SLOT_DEPTH + 1) / 2;
    localparam int ODD_DEPTH  = SLOT_DEPTH / 2;
    localparam int EAW        = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
    localparam int OAW        = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
    localparam int SUW        = tos_pkg::LIMIT_W;
    localparam int LW         = ((CW > SUW) ? CW : SUW) + 1;
    localparam int TW         = tos_pkg::TYPE_W + REAL_TYPE_BITS;
    localparam int RIW        = tos_pkg::RT_IN_W;
    localparam int RXW        = (REAL_TYPE_BITS > RIW) ? REAL_TYPE_BITS : RIW;
    localparam int SW         = tos_pkg::SLOT_W;
    localparam int VW         = tos_pkg::VALUE_W;
    localparam int TYW        = tos_pkg::TYPE_W;
    localparam int RTW        = tos_pkg::RTYPE_W;

    localparam logic [LW-1:0] DEPTH_L = LW'(SLOT_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(SLOT_DEPTH);

    // Control state
    logic [CW-1:0]  slot_count_reg, slot_count_next;
    logic [CW-1:0]  entry_count_reg, entry_count_next;
    logic [SUW-1:0] slot_limit_reg;
    logic           wide_refs_reg;
    logic           out_valid_reg, out_valid_next;

    // Same-edge write forwarding
    logic           tag_fwd_reg, tag_fwd_next;
    logic [TW-1:0]  tag_fwd_data_reg;
    logic           even_fwd_reg, even_fwd_next;
    logic [SW-1:0]  even_fwd_data_reg;
    logic           odd_fwd_reg, odd_fwd_next;
    logic [SW-1:0]  odd_fwd_data_reg;

    // Result register
    logic [VW-1:0]                   result_value_reg;
    logic [RTW-1:0]                  result_type_reg;
    logic [RIW-1:0]                  result_real_reg;
    logic [tos_pkg::STATUS_W-1:0]    status_reg;
    logic [SUW-1:0]                  slots_used_reg;
    logic                            is_empty_reg;

    // RAM ports
    logic           tag_we;
    logic [AW-1:0]  tag_waddr, tag_raddr;
    logic [TW-1:0]  tag_wdata, tag_q;
    logic           even_we;
    logic [EAW-1:0] even_waddr, even_raddr;
    logic [SW-1:0]  even_wdata, even_q;
    logic           odd_we;
    logic [OAW-1:0] odd_waddr, odd_raddr;
    logic [SW-1:0]  odd_wdata, odd_q;

    // Current top of stack
    logic [TW-1:0]             top_tag;
    logic [TYW-1:0]            top_base;
    logic [REAL_TYPE_BITS-1:0] top_rt;
    logic                      top_two;
    logic [SW-1:0]             even_word, odd_word, word0, word1;
    logic                      top_is_odd;

    // Push decode
    logic                      accept;
    logic                      push_two;
    logic [LW-1:0]             push_need;
    logic [LW-1:0]             limit_l;
    logic                      push_over;
    logic                      type_known;
    logic [SW-1:0]             lo_word;
    logic [RIW-1:0]            rt_src;
    logic [RXW-1:0]            rt_ext;
    logic [TW-1:0]             new_tag;
    logic [CW-1:0]             hi_idx;
    logic                      lo_odd;

    // Operation results
    logic                      do_push;
    logic [VW-1:0]             rvalue;
    logic [RTW-1:0]            rtype;
    logic [REAL_TYPE_BITS-1:0] rreal;
    logic [RXW-1:0]            rreal_ext;
    logic [tos_pkg::STATUS_W-1:0] rstatus;
    logic [CW-1:0]             t0_idx, t1_idx;

    tos_ram #(.WIDTH(TW), .DEPTH(SLOT_DEPTH)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_q)
    );

    tos_ram #(.WIDTH(SW), .DEPTH(EVEN_DEPTH)) u_even_ram (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .raddr (even_raddr),
        .rdata (even_q)
    );

    tos_ram #(.WIDTH(SW), .DEPTH(ODD_DEPTH)) u_odd_ram (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .raddr (odd_raddr),
        .rdata (odd_q)
    );

    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    // Top entry, taking a write that landed on the prefetched address
    assign top_tag    = tag_fwd_reg ? tag_fwd_data_reg : tag_q;
    assign top_base   = top_tag[TYW-1:0];
    assign top_rt     = top_tag[TW-1:TYW];
    assign top_two    = tos_pkg::takes_two(top_base, wide_refs_reg);
    assign even_word  = even_fwd_reg ? even_fwd_data_reg : even_q;
    assign odd_word   = odd_fwd_reg ? odd_fwd_data_reg : odd_q;
    assign top_is_odd = ~slot_count_reg[0];

    // Slots below the bottom read as zero
    assign word0 = (slot_count_reg != '0) ? (top_is_odd ? odd_word : even_word) : '0;
    assign word1 = (slot_count_reg > CW'(1)) ? (top_is_odd ? even_word : odd_word) : '0;

    assign push_two   = tos_pkg::takes_two(type_tag, wide_refs_reg);
    assign push_need  = push_two ? LW'(2) : LW'(1);
    assign limit_l    = (LW'(slot_limit_reg) < DEPTH_L) ? LW'(slot_limit_reg) : DEPTH_L;
    assign push_over  = ((LW'(slot_count_reg) + push_need) > limit_l)
                        || (entry_count_reg >= DEPTH_C);
    assign type_known = (type_tag <= tos_pkg::TAG_REF);
    assign lo_word    = (type_tag == tos_pkg::TAG_BOOL) ? SW'(|value[7:0]) : value[SW-1:0];
    assign rt_src     = real_type_given ? real_type : RIW'(type_tag);
    assign rt_ext     = RXW'(rt_src);
    assign new_tag    = {rt_ext[REAL_TYPE_BITS-1:0], type_tag};

    always_comb
    begin
        slot_count_next  = slot_count_reg;
        entry_count_next = entry_count_reg;
        do_push          = 1'b0;
        rvalue           = '0;
        rreal            = '0;
        rstatus          = tos_pkg::STATUS_OK;
        rtype            = (entry_count_reg != '0) ? RTW'(top_base) : tos_pkg::TYPE_NONE;
        if (accept)
        begin
            case (kind)
                tos_pkg::KIND_PUSH:
                begin
                    if (type_known)
                    begin
                        if (push_over)
                        begin
                            rstatus = tos_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            do_push          = 1'b1;
                            slot_count_next  = slot_count_reg + (push_two ? CW'(2) : CW'(1));
                            entry_count_next = entry_count_reg + CW'(1);
                            rtype            = RTW'(type_tag);
                        end
                    end
                end
                tos_pkg::KIND_POP,
                tos_pkg::KIND_PEEK:
                begin
                    if (entry_count_reg == '0)
                    begin
                        rstatus = tos_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        rvalue = top_two ? {word0, word1} : VW'(word0);
                        rreal  = top_rt;
                        if (kind == tos_pkg::KIND_POP)
                        begin
                            entry_count_next = entry_count_reg - CW'(1);
                            if (top_two)
                            begin
                                slot_count_next = (slot_count_reg > CW'(2))
                                                  ? slot_count_reg - CW'(2) : '0;
                            end
                            else
                            begin
                                slot_count_next = (slot_count_reg > CW'(1))
                                                  ? slot_count_reg - CW'(1) : '0;
                            end
                            if (entry_count_next == '0)
                            begin
                                slot_count_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Push writes: low word at slot_count, high word in the other bank above it
    assign lo_odd     = slot_count_reg[0];
    assign hi_idx     = slot_count_reg + CW'(1);
    assign even_we    = do_push & (~lo_odd | push_two);
    assign even_waddr = lo_odd ? EAW'(hi_idx >> 1) : EAW'(slot_count_reg >> 1);
    assign even_wdata = lo_odd ? value[VW-1:SW] : lo_word;
    assign odd_we     = do_push & (lo_odd | push_two);
    assign odd_waddr  = lo_odd ? OAW'(slot_count_reg >> 1) : OAW'(hi_idx >> 1);
    assign odd_wdata  = lo_odd ? lo_word : value[VW-1:SW];
    assign tag_we     = do_push;
    assign tag_waddr  = AW'(entry_count_reg);
    assign tag_wdata  = new_tag;

    // Prefetch the top two slots and the top tag of the next state
    assign t0_idx     = slot_count_next - CW'(1);
    assign t1_idx     = slot_count_next - CW'(2);
    assign even_raddr = slot_count_next[0] ? EAW'(t0_idx >> 1) : EAW'(t1_idx >> 1);
    assign odd_raddr  = slot_count_next[0] ? OAW'(t1_idx >> 1) : OAW'(t0_idx >> 1);
    assign tag_raddr  = AW'(entry_count_next - CW'(1));

    assign tag_fwd_next  = tag_we && (tag_waddr == tag_raddr);
    assign even_fwd_next = even_we && (even_waddr == even_raddr);
    assign odd_fwd_next  = odd_we && (odd_waddr == odd_raddr);

    assign out_valid_next = accept | in_stall;
    assign rreal_ext      = RXW'(rreal);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  <= '0;
            entry_count_reg <= '0;
            slot_limit_reg  <= tos_pkg::SLOT_LIMIT_RESET;
            wide_refs_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            tag_fwd_reg     <= 1'b0;
            even_fwd_reg    <= 1'b0;
            odd_fwd_reg     <= 1'b0;
        end
        else
        begin
            slot_count_reg  <= slot_count_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
            tag_fwd_reg     <= tag_fwd_next;
            even_fwd_reg    <= even_fwd_next;
            odd_fwd_reg     <= odd_fwd_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tos_pkg::REG_SLOT_LIMIT: slot_limit_reg <= cfg_data;
                    tos_pkg::REG_WIDE_REFS:  wide_refs_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_fwd_data_reg  <= tag_wdata;
        even_fwd_data_reg <= even_wdata;
        odd_fwd_data_reg  <= odd_wdata;
        if (accept)
        begin
            result_value_reg <= rvalue;
            result_type_reg  <= rtype;
            result_real_reg  <= rreal_ext[RIW-1:0];
            status_reg       <= rstatus;
            slots_used_reg   <= SUW'(slot_count_next);
            is_empty_reg     <= (entry_count_next == '0);
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_value     = result_value_reg;
    assign result_type      = result_type_reg;
    assign result_real_type = result_real_reg;
    assign status           = status_reg;
    assign slots_used       = slots_used_reg;
    assign is_empty         = is_empty_reg;

endmodule

/* verif/operand_stack_checker.sv */
// Checker for the typed operand stack: tracks the stack contents, predicts each reply and compares.
module operand_stack_checker #(
    parameter int SLOT_DEPTH = tos_pkg::SLOT_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [tos_pkg::KIND_W-1:0]      kind,
    input  logic [tos_pkg::VALUE_W-1:0]     value,
    input  logic [tos_pkg::TYPE_W-1:0]      type_tag,
    input  logic [tos_pkg::RT_IN_W-1:0]     real_type,
    input  logic                            real_type_given,

    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [tos_pkg::VALUE_W-1:0]     result_value,
    input  logic [tos_pkg::RTYPE_W-1:0]     result_type,
    input  logic [tos_pkg::RT_IN_W-1:0]     result_real_type,
    input  logic [tos_pkg::STATUS_W-1:0]    status,
    input  logic [tos_pkg::LIMIT_W-1:0]     slots_used,
    input  logic                            is_empty,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tos_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tos_pkg::LIMIT_W-1:0]     cfg_data,

    output int unsigned                     mismatches,
    output int unsigned                     outstanding,
    output int unsigned                     results_checked,
    output int unsigned                     refused_pushes,
    output int unsigned                     empty_reads
);

    timeunit 1ns;
    timeprecision 1ps;

    import tos_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [RTYPE_W-1:0]  rtype;
        logic [RT_IN_W-1:0]  real_type;
        logic [STATUS_W-1:0] status;
        logic [LIMIT_W-1:0]  slots;
        logic                empty;
    } stack_reply_t;

    logic [SLOT_W-1:0]         slot_mem [SLOT_DEPTH];
    // real type above, type tag in the low bits
    logic [RT_IN_W+TYPE_W-1:0] tag_mem  [SLOT_DEPTH];
    int unsigned               used_slots;
    int unsigned               entries;
    int unsigned               limit_now;
    logic                      wide_now;
    stack_reply_t              replies_due [$];

    function automatic int unsigned slot_need(input logic [TYPE_W-1:0] tag);
        if (tag == TAG_LONG || tag == TAG_DOUBLE || (tag == TAG_REF && wide_now))
            return 2;
        return 1;
    endfunction

    // Slots below the bottom read as zero
    function automatic logic [SLOT_W-1:0] slot_below_top(input int unsigned depth);
        if (depth >= used_slots)
            return '0;
        return slot_mem[used_slots - 1 - depth];
    endfunction

    task automatic apply_stack_op(
        input  logic [KIND_W-1:0]  op,
        input  logic [VALUE_W-1:0] val,
        input  logic [TYPE_W-1:0]  tag,
        input  logic [RT_IN_W-1:0] rt,
        input  logic               rt_given,
        output stack_reply_t       reply
    );
        int unsigned               need;
        int unsigned               cap;
        logic [SLOT_W-1:0]         lo;
        logic [RT_IN_W+TYPE_W-1:0] top;
        reply.value     = '0;
        reply.rtype     = TYPE_NONE;
        reply.real_type = '0;
        reply.status    = STATUS_OK;
        cap = (limit_now < SLOT_DEPTH) ? limit_now : SLOT_DEPTH;
        if (op == KIND_PUSH)
        begin
            if (tag <= TAG_REF)
            begin
                need = slot_need(tag);
                if (used_slots + need > cap || entries >= SLOT_DEPTH)
                begin
                    reply.status = STATUS_OVERFLOW;
                    refused_pushes++;
                end
                else
                begin
                    lo = val[SLOT_W-1:0];
                    if (tag == TAG_BOOL)
                        lo = (val[7:0] != '0) ? 32'd1 : 32'd0;
                    slot_mem[used_slots] = lo;
                    used_slots++;
                    if (need == 2)
                    begin
                        slot_mem[used_slots] = val[VALUE_W-1:SLOT_W];
                        used_slots++;
                    end
                    tag_mem[entries] = {rt_given ? rt : RT_IN_W'(tag), tag};
                    entries++;
                end
            end
            if (entries != 0)
                reply.rtype = RTYPE_W'(tag_mem[entries-1][TYPE_W-1:0]);
        end
        else if (op == KIND_POP || op == KIND_PEEK)
        begin
            if (entries == 0)
            begin
                reply.status = STATUS_EMPTY;
                empty_reads++;
            end
            else
            begin
                top = tag_mem[entries-1];
                need = slot_need(top[TYPE_W-1:0]);
                reply.rtype     = RTYPE_W'(top[TYPE_W-1:0]);
                reply.real_type = top[RT_IN_W+TYPE_W-1:TYPE_W];
                if (need == 2)
                    reply.value = {slot_below_top(0), slot_below_top(1)};
                else
                    reply.value = VALUE_W'(slot_below_top(0));
                if (op == KIND_POP)
                begin
                    used_slots = (used_slots > need) ? used_slots - need : 0;
                    entries--;
                    if (entries == 0)
                        used_slots = 0;
                end
            end
        end
        else if (entries != 0)
        begin
            reply.rtype = RTYPE_W'(tag_mem[entries-1][TYPE_W-1:0]);
        end
        reply.slots = LIMIT_W'(used_slots);
        reply.empty = (entries == 0);
    endtask

    task automatic report_mismatch(
        input string              what,
        input logic [VALUE_W-1:0] got,
        input logic [VALUE_W-1:0] want
    );
        mismatches++;
        $display("%0d ns: reply %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, results_checked, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stack_reply_t fresh;
        stack_reply_t want;
        if (!rst_n)
        begin
            replies_due.delete();
            used_slots      = 0;
            entries         = 0;
            limit_now       = SLOT_LIMIT_RESET;
            wide_now        = 1'b0;
            mismatches      = 0;
            outstanding     = 0;
            results_checked = 0;
            refused_pushes  = 0;
            empty_reads     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SLOT_LIMIT)
                    limit_now = cfg_data;
                else if (cfg_index == REG_WIDE_REFS)
                    wide_now = cfg_data[0];
            end
            if (in_valid && !in_stall)
            begin
                apply_stack_op(kind, value, type_tag, real_type, real_type_given, fresh);
                replies_due.push_back(fresh);
            end
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (replies_due.size() == 0)
                begin
                    report_mismatch("reply with no word waiting", result_value, '0);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (result_value !== want.value)
                        report_mismatch("result_value", result_value, want.value);
                    if (result_type !== want.rtype)
                        report_mismatch("result_type", VALUE_W'(result_type),
                                        VALUE_W'(want.rtype));
                    if (result_real_type !== want.real_type)
                        report_mismatch("result_real_type", VALUE_W'(result_real_type),
                                        VALUE_W'(want.real_type));
                    if (status !== want.status)
                        report_mismatch("status", VALUE_W'(status), VALUE_W'(want.status));
                    if (slots_used !== want.slots)
                        report_mismatch("slots_used", VALUE_W'(slots_used),
                                        VALUE_W'(want.slots));
                    if (is_empty !== want.empty)
                        report_mismatch("is_empty", VALUE_W'(is_empty), VALUE_W'(want.empty));
                end
            end
            outstanding = replies_due.size();
        end
    end

endmodule

/* verif/typed_operand_stack_test.sv */
// Top of the typed operand stack testbench: clock, reset, stimulus and verdict.
module typed_operand_stack_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tos_pkg::*;

    // Codes the block must tolerate but does not define
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    localparam logic [TYPE_W-1:0] TAG_UNUSED_A = 3'd6;
    localparam logic [TYPE_W-1:0] TAG_UNUSED_B = 3'd7;

    localparam int unsigned ALTERNATE   = 0;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_pattern_t;

    logic                   clk             = 1'b0;
    logic                   rst_n           = 1'b0;

    logic                   in_valid        = 1'b0;
    logic                   in_stall;
    logic [KIND_W-1:0]      kind            = KIND_PUSH;
    logic [VALUE_W-1:0]     value           = '0;
    logic [TYPE_W-1:0]      type_tag        = TAG_INT;
    logic [RT_IN_W-1:0]     real_type       = '0;
    logic                   real_type_given = 1'b0;

    logic                   out_valid;
    logic                   out_stall       = 1'b0;
    logic [VALUE_W-1:0]     result_value;
    logic [RTYPE_W-1:0]     result_type;
    logic [RT_IN_W-1:0]     result_real_type;
    logic [STATUS_W-1:0]    status;
    logic [LIMIT_W-1:0]     slots_used;
    logic                   is_empty;

    logic                   cfg_valid       = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index       = '0;
    logic [LIMIT_W-1:0]     cfg_data        = '0;

    int unsigned            mismatches;
    int unsigned            outstanding;
    int unsigned            results_checked;
    int unsigned            refused_pushes;
    int unsigned            empty_reads;

    int unsigned            words_sent      = 0;
    int unsigned            cfg_writes      = 0;
    int unsigned            burst_left      = 0;
    int unsigned            cycle_count     = 0;
    int unsigned            stall_left      = 0;
    stall_pattern_t         stall_mode      = STALL_NONE;

    typed_operand_stack i_dut (.*);

    operand_stack_checker i_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: switch between randomly chosen stall patterns
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_pattern_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 120);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= stall_left[2];
        endcase
    end

    // Hold the word until it is taken, then idle between bursts
    task automatic send_word(
        input logic [KIND_W-1:0]  op,
        input logic [VALUE_W-1:0] val,
        input logic [TYPE_W-1:0]  tag,
        input logic [RT_IN_W-1:0] rt,
        input logic               rt_given
    );
        in_valid        <= 1'b1;
        kind            <= op;
        value           <= val;
        type_tag        <= tag;
        real_type       <= rt;
        real_type_given <= rt_given;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic send_random(input int unsigned push_pct);
        logic [KIND_W-1:0]  op;
        logic [VALUE_W-1:0] val;
        logic [TYPE_W-1:0]  tag;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
        begin
            op = KIND_PUSH;
        end
        else
        begin
            pick = $urandom_range(0, 19);
            op = (pick == 0) ? KIND_UNUSED : (pick < 7) ? KIND_PEEK : KIND_POP;
        end
        if ($urandom_range(0, 15) == 0)
            tag = $urandom_range(0, 1) ? TAG_UNUSED_A : TAG_UNUSED_B;
        else
            tag = TYPE_W'($urandom_range(TAG_INT, TAG_REF));
        case ($urandom_range(0, 7))
            0:       val = '0;
            1:       val = '1;
            // a bool that must read back as false
            2:       val = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00;
            3:       val = VALUE_W'($urandom_range(0, 255));
            default: val = {$urandom, $urandom};
        endcase
        send_word(op, val, tag, RT_IN_W'($urandom), 1'($urandom));
    endtask

    // Stack contents carry over from one setting to the next
    task automatic run_phase(
        input logic [LIMIT_W-1:0] limit,
        input logic               wide,
        input int unsigned        count,
        input int unsigned        push_pct
    );
        int unsigned run_left;
        logic        push_heavy;
        write_reg(REG_SLOT_LIMIT, limit);
        write_reg(REG_WIDE_REFS, LIMIT_W'(wide));
        run_left   = 0;
        push_heavy = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if (push_pct == ALTERNATE && run_left == 0)
            begin
                push_heavy = !push_heavy;
                run_left   = $urandom_range(4, 20);
            end
            send_random((push_pct != ALTERNATE) ? push_pct : (push_heavy ? 70 : 35));
            if (run_left != 0)
                run_left--;
            if (n == count / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Four slots: mixes one- and two-slot entries against the limit
        write_reg(REG_SLOT_LIMIT, 9'd4);
        write_reg(REG_WIDE_REFS, 9'd0);
        send_word(KIND_POP, '0, TAG_INT, '0, 1'b0);
        send_word(KIND_PEEK, '0, TAG_INT, '0, 1'b0);
        send_word(KIND_UNUSED, '1, TAG_INT, '0, 1'b0);
        send_word(KIND_PUSH, '1, TAG_INT, 4'hF, 1'b1);
        send_word(KIND_PUSH, 64'h0123_4567_89AB_CDEF, TAG_LONG, 4'h9, 1'b1);
        send_word(KIND_PUSH, 64'hFFFF_FFFF_0000_0001, TAG_DOUBLE, '0, 1'b0);
        send_word(KIND_PUSH, '0, TAG_FLOAT, 4'hA, 1'b0);
        send_word(KIND_PUSH, 64'hDEAD_BEEF_CAFE_F00D, TAG_REF, 4'h3, 1'b1);
        send_word(KIND_PUSH, '1, TAG_UNUSED_A, '1, 1'b1);
        send_word(KIND_PUSH, '1, TAG_UNUSED_B, '0, 1'b0);
        send_word(KIND_PEEK, '0, TAG_INT, '0, 1'b0);
        send_word(KIND_UNUSED, '0, TAG_INT, '0, 1'b0);
        send_word(KIND_POP, '0, TAG_INT, '0, 1'b0);
        send_word(KIND_POP, '0, TAG_INT, '0, 1'b0);
        send_word(KIND_PUSH, 64'hFFFF_FFFF_FFFF_FF00, TAG_BOOL, '0, 1'b0);
        send_word(KIND_PUSH, 64'h0000_0000_0000_0080, TAG_BOOL, 4'h0, 1'b1);
        send_word(KIND_PUSH, 64'hDEAD_BEEF_CAFE_F00D, TAG_REF, '0, 1'b0);
        send_word(KIND_PUSH, '1, TAG_DOUBLE, 4'h5, 1'b1);
        repeat (5)
            send_word(KIND_POP, '0, TAG_INT, '0, 1'b0);

        // fill to the top, then drain with references read two slots wide
        run_phase(9'd256, 1'b0, 330, 80);
        run_phase(9'd256, 1'b1, 250, 10);
        run_phase(9'd1, 1'b1, 60, ALTERNATE);
        run_phase(9'd2, 1'b0, 60, ALTERNATE);
        run_phase(9'd3, 1'b1, 60, ALTERNATE);
        run_phase(9'd5, 1'b0, 60, ALTERNATE);
        run_phase(9'd64, 1'b1, 100, ALTERNATE);
        run_phase(9'd255, 1'b0, 100, ALTERNATE);
        run_phase(LIMIT_W'($urandom_range(1, 256)), 1'($urandom), 100, ALTERNATE);

        wait_drained();
        repeat (8)
            @(posedge clk);

        $display("Sent %0d words over %0d register writes; checked %0d results,",
                 words_sent, cfg_writes, results_checked);
        $display("including %0d refused pushes and %0d reads of an empty stack.",
                 refused_pushes, empty_reads);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
